[sv/xfse_pkg.sv]
// shared types, widths and helper functions for the xor float stream encoder
// used by every module of the block; no dependencies
`default_nettype none

package xfse_pkg;

   localparam int VALUE_W   = 32;
   localparam int LEAD_W    = 5;
   localparam int MLEN_W    = 6;
   localparam int HDR_W     = 2 + LEAD_W + MLEN_W;
   localparam int CHUNK_W   = 45;
   localparam int LEN_W     = 6;
   localparam int SEEN_W    = 16;
   localparam int WLEAD_W   = 8;
   localparam int TRAIL_W   = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [SEEN_W-1:0]  MAX_VALUES_RESET = 16'd50;
   localparam logic [WLEAD_W-1:0] NO_WINDOW        = 8'd255;

   // register index decoded from paddr[2]
   localparam logic REG_MAX_VALUES = 1'b0;

   typedef enum logic [2:0] {
      KIND_REJECT,
      KIND_RAW,
      KIND_ZERO,
      KIND_REUSE,
      KIND_FRESH
   } kind_type;

   // one classified item, handed from the front to the back
   typedef struct packed {
      kind_type                kind;
      logic [VALUE_W-1:0]      word;
      logic [LEAD_W-1:0]       shift;
      logic [MLEN_W-1:0]       mlen;
      logic [LEAD_W-1:0]       lead;
   } rec_type;

   // leading zero count, binary search in five steps; x is nonzero where used
   function automatic logic [LEAD_W-1:0] clz32(input logic [VALUE_W-1:0] x);
      logic [VALUE_W-1:0] v;
      logic [LEAD_W-1:0]  n;
      v = x;
      n = '0;
      if (v[31:16] == 16'd0) begin
         n[4] = 1'b1;
         v = v << 16;
      end
      if (v[31:24] == 8'd0) begin
         n[3] = 1'b1;
         v = v << 8;
      end
      if (v[31:28] == 4'd0) begin
         n[2] = 1'b1;
         v = v << 4;
      end
      if (v[31:30] == 2'd0) begin
         n[1] = 1'b1;
         v = v << 2;
      end
      if (v[31] == 1'b0) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

   function automatic logic [LEAD_W-1:0] ctz32(input logic [VALUE_W-1:0] x);
      logic [VALUE_W-1:0] r;
      for (int i = 0; i < VALUE_W; i++) begin
         r[i] = x[VALUE_W-1-i];
      end
      return clz32(r);
   endfunction

endpackage

`default_nettype wire

[sv/xfse_front.sv]
// front part: accepts values, xors with the previous one, classifies the chunk
// and keeps the window and value count; uses xfse_pkg
`default_nettype none

module xfse_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             take,
   input  wire logic [xfse_pkg::VALUE_W-1:0]     value_bits,
   input  wire logic [xfse_pkg::SEEN_W-1:0]      max_values,
   output xfse_pkg::rec_type                     rec
);

   logic [xfse_pkg::VALUE_W-1:0] prev_ff, prev_in;
   logic [xfse_pkg::SEEN_W-1:0]  seen_ff, seen_in;
   logic [xfse_pkg::WLEAD_W-1:0] wlead_ff, wlead_in;
   logic [xfse_pkg::TRAIL_W-1:0] wtrail_ff, wtrail_in;

   logic [xfse_pkg::VALUE_W-1:0] x;
   logic [xfse_pkg::LEAD_W-1:0]  lead;
   logic [xfse_pkg::LEAD_W-1:0]  trail;
   logic                         limit;
   logic                         fits;

   always_comb begin
      x     = value_bits ^ prev_ff;
      lead  = xfse_pkg::clz32(x);
      trail = xfse_pkg::ctz32(x);
      limit = seen_ff >= max_values;
      fits  = (wlead_ff <= xfse_pkg::WLEAD_W'(lead)) &&
              (wtrail_ff <= xfse_pkg::TRAIL_W'(trail));

      prev_in   = prev_ff;
      seen_in   = seen_ff;
      wlead_in  = wlead_ff;
      wtrail_in = wtrail_ff;

      rec.kind  = xfse_pkg::KIND_REJECT;
      rec.word  = '0;
      rec.shift = '0;
      rec.mlen  = '0;
      rec.lead  = '0;

      if (!limit) begin
         prev_in = value_bits;
         seen_in = seen_ff + xfse_pkg::SEEN_W'(1);
         if (seen_ff == '0) begin
            rec.kind = xfse_pkg::KIND_RAW;
            rec.word = value_bits;
            rec.mlen = xfse_pkg::MLEN_W'(xfse_pkg::VALUE_W);
         end else if (x == '0) begin
            rec.kind = xfse_pkg::KIND_ZERO;
         end else if (fits) begin
            rec.kind  = xfse_pkg::KIND_REUSE;
            rec.word  = x;
            rec.shift = wtrail_ff[xfse_pkg::LEAD_W-1:0];
            rec.mlen  = xfse_pkg::MLEN_W'(xfse_pkg::VALUE_W)
                        - {1'b0, wlead_ff[xfse_pkg::LEAD_W-1:0]}
                        - {1'b0, wtrail_ff[xfse_pkg::LEAD_W-1:0]};
         end else begin
            rec.kind  = xfse_pkg::KIND_FRESH;
            rec.word  = x;
            rec.shift = trail;
            rec.lead  = lead;
            rec.mlen  = xfse_pkg::MLEN_W'(xfse_pkg::VALUE_W)
                        - {1'b0, lead} - {1'b0, trail};
            wlead_in  = xfse_pkg::WLEAD_W'(lead);
            wtrail_in = xfse_pkg::TRAIL_W'(trail);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff   <= '0;
         seen_ff   <= '0;
         wlead_ff  <= xfse_pkg::NO_WINDOW;
         wtrail_ff <= '0;
      end else if (take) begin
         prev_ff   <= prev_in;
         seen_ff   <= seen_in;
         wlead_ff  <= wlead_in;
         wtrail_ff <= wtrail_in;
      end
   end

endmodule

`default_nettype wire

[sv/xfse_queue.sv]
// small register queue of classified items between the front and the back
// uses xfse_pkg for the item record
`default_nettype none

module xfse_queue #(
   parameter int DEPTH = xfse_pkg::QUEUE_DEPTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire xfse_pkg::rec_type push_rec,
   output logic                   full,
   input  wire logic              pop,
   output xfse_pkg::rec_type      head,
   output logic                   head_valid
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   xfse_pkg::rec_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   always_comb begin
      full       = cnt_ff == CNT_W'(DEPTH);
      head_valid = cnt_ff != '0;
      head       = entries_ff[rd_ff];

      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ff] <= push_rec;
      end
   end

endmodule

`default_nettype wire

[sv/xfse_back.sv]
// back part: builds the msb-first bit chunk from a classified item and holds
// it in the result register; uses xfse_pkg
`default_nettype none

module xfse_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire xfse_pkg::rec_type               rec,
   input  wire logic                            rec_valid,
   output logic                                 rec_take,
   input  wire logic                            out_pop,
   output logic                                 out_valid,
   output logic                                 out_accepted,
   output logic [xfse_pkg::CHUNK_W-1:0]         out_bits,
   output logic [xfse_pkg::LEN_W-1:0]           out_length
);

   logic                          valid_ff;
   logic                          acc_ff, acc_in;
   logic [xfse_pkg::CHUNK_W-1:0]  bits_ff, bits_in;
   logic [xfse_pkg::LEN_W-1:0]    len_ff, len_in;

   logic [xfse_pkg::VALUE_W-1:0]  payload;
   logic [xfse_pkg::HDR_W-1:0]    hdr;
   logic [xfse_pkg::LEN_W-1:0]    hlen;

   always_comb begin
      rec_take = rec_valid && (!valid_ff || out_pop);
      payload  = rec.word >> rec.shift;
      hdr      = '0;
      hlen     = '0;
      acc_in   = 1'b1;

      unique case (rec.kind)
         xfse_pkg::KIND_RAW: begin
            hlen = '0;
         end
         xfse_pkg::KIND_ZERO: begin
            hlen = xfse_pkg::LEN_W'(1);
         end
         xfse_pkg::KIND_REUSE: begin
            hdr  = xfse_pkg::HDR_W'(2'b10);
            hlen = xfse_pkg::LEN_W'(2);
         end
         xfse_pkg::KIND_FRESH: begin
            hdr  = {2'b11, rec.lead, rec.mlen};
            hlen = xfse_pkg::LEN_W'(xfse_pkg::HDR_W);
         end
         default: begin
            acc_in = 1'b0;
         end
      endcase

      if (acc_in) begin
         bits_in = (xfse_pkg::CHUNK_W'(hdr) << rec.mlen) | xfse_pkg::CHUNK_W'(payload);
         len_in  = hlen + rec.mlen;
      end else begin
         bits_in = '0;
         len_in  = '0;
      end

      out_valid    = valid_ff;
      out_accepted = acc_ff;
      out_bits     = bits_ff;
      out_length   = len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (rec_take) begin
         valid_ff <= 1'b1;
      end else if (out_pop) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take) begin
         acc_ff  <= acc_in;
         bits_ff <= bits_in;
         len_ff  <= len_in;
      end
   end

endmodule

`default_nettype wire

[sv/xor_float_stream_encoder_unit.sv]
// xor float stream encoder: one float bit pattern in, one msb-first bit chunk out.
// the front holds the xor state, the back the shifter; a value passes the queue
// and then the result register; throughput: one value per cycle while not full.
// the queue between them holds QUEUE_DEPTH items; full rises when it fills up.
// synchronous reset clears the value history, window, queue and result; max_values -> 50.
`default_nettype none

module xor_float_stream_encoder_unit #(
   parameter int QUEUE_DEPTH = xfse_pkg::QUEUE_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic [xfse_pkg::VALUE_W-1:0]       req_value_bits,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic                                    rsp_accepted,
   output logic [xfse_pkg::CHUNK_W-1:0]            rsp_chunk_bits,
   output logic [xfse_pkg::LEN_W-1:0]              rsp_chunk_length,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [xfse_pkg::CSR_ADDR_W-1:0]    paddr,
   input  wire logic [xfse_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [xfse_pkg::CSR_DATA_W-1:0]         prdata,
   output logic                                    pready
);

   logic [xfse_pkg::SEEN_W-1:0] max_values_ff;
   logic                        csr_write;

   logic                        q_full;
   logic                        q_push;
   logic                        q_pop;
   logic                        q_head_valid;
   xfse_pkg::rec_type           front_rec;
   xfse_pkg::rec_type           q_head;
   logic                        out_valid;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[2] == xfse_pkg::REG_MAX_VALUES)
                      ? xfse_pkg::CSR_DATA_W'(max_values_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_values_ff <= xfse_pkg::MAX_VALUES_RESET;
      end else if (csr_write && paddr[2] == xfse_pkg::REG_MAX_VALUES) begin
         max_values_ff <= pwdata[xfse_pkg::SEEN_W-1:0];
      end
   end

   assign full   = q_full;
   assign q_push = push && !q_full;
   assign empty  = !out_valid;

   xfse_front u_front (
      .clock      (clock),
      .reset      (reset),
      .take       (q_push),
      .value_bits (req_value_bits),
      .max_values (max_values_ff),
      .rec        (front_rec)
   );

   xfse_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_rec   (front_rec),
      .full       (q_full),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid)
   );

   xfse_back u_back (
      .clock        (clock),
      .reset        (reset),
      .rec          (q_head),
      .rec_valid    (q_head_valid),
      .rec_take     (q_pop),
      .out_pop      (pop && !empty),
      .out_valid    (out_valid),
      .out_accepted (rsp_accepted),
      .out_bits     (rsp_chunk_bits),
      .out_length   (rsp_chunk_length)
   );

   // a dropped value carries no bits
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_accepted) |-> (rsp_chunk_length == '0 && rsp_chunk_bits == '0))
      else $error("rejected result carries chunk data");

   // nothing set above the chunk length
   assert property (@(posedge clock) disable iff (reset)
      !empty |-> ((rsp_chunk_bits >> rsp_chunk_length) == '0))
      else $error("chunk bits beyond chunk length");

   // an encoded value always emits at least one bit, at most 45
   assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_accepted) |->
         (rsp_chunk_length != '0 && rsp_chunk_length <= xfse_pkg::LEN_W'(xfse_pkg::CHUNK_W)))
      else $error("bad chunk length for encoded value");

endmodule

`default_nettype wire

[sim/tb.sv]
// self-checking bench for xor_float_stream_encoder_unit: directed table, then random traffic
// keeps its own model of the xor window encoder and checks every result transfer
// depends on xfse_pkg and the encoder rtl
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS   = 630;
   localparam int PHASE_ITEMS    = 60;
   localparam int OPEN_TAIL      = 80;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int DRAIN_CYCLES   = 4;

   localparam logic [xfse_pkg::CSR_ADDR_W-1:0] ADDR_MAX_VALUES = {xfse_pkg::REG_MAX_VALUES, 2'b00};
   localparam logic [xfse_pkg::CSR_ADDR_W-1:0] ADDR_SPARE      = 3'd4;

   typedef struct packed {
      logic                         accepted;
      logic [xfse_pkg::CHUNK_W-1:0] bits;
      logic [xfse_pkg::LEN_W-1:0]   len;
   } chunk_type;

   typedef enum {ROW_PUSH, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      logic [xfse_pkg::CSR_ADDR_W-1:0] addr;
      logic [31:0]                     data;
      bit                              typed;
      chunk_type                       want;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic push = 1'b0;
   logic [xfse_pkg::VALUE_W-1:0] req_value_bits = '0;
   logic pop = 1'b0;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [xfse_pkg::CSR_ADDR_W-1:0] paddr = '0;
   logic [xfse_pkg::CSR_DATA_W-1:0] pwdata = '0;

   logic full, empty, rsp_accepted, pready;
   logic [xfse_pkg::CHUNK_W-1:0]    rsp_chunk_bits;
   logic [xfse_pkg::LEN_W-1:0]      rsp_chunk_length;
   logic [xfse_pkg::CSR_DATA_W-1:0] prdata;

   xor_float_stream_encoder_unit dut (
      .clock(clock), .reset(reset),
      .push(push), .full(full), .req_value_bits(req_value_bits),
      .empty(empty), .pop(pop), .rsp_accepted(rsp_accepted),
      .rsp_chunk_bits(rsp_chunk_bits), .rsp_chunk_length(rsp_chunk_length),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // encoder model state
   logic [15:0] cap_limit  = xfse_pkg::MAX_VALUES_RESET;
   logic [31:0] last_sample = '0;
   logic [7:0]  win_lead   = xfse_pkg::NO_WINDOW;
   logic [5:0]  win_trail  = '0;
   logic [15:0] seen_count = '0;

   chunk_type pending_chunks[$];
   chunk_type head;
   int errors = 0;
   int results = 0;
   int pop_hold = 0;
   int stall_cycles = 0;
   bit tx_calm = 1'b0;
   bit rx_calm = 1'b0;

   row_type plan [22] = '{
      '{ROW_PUSH,  '0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 45'hFFFF_FFFF, 6'd32}},
      '{ROW_PUSH,  '0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 45'h0, 6'd1}},
      '{ROW_PUSH,  '0, 32'h8000_0000, 1'b1, '{1'b1, 45'hC2F_FFFF_FFFF, 6'd44}},
      '{ROW_PUSH,  '0, 32'h8000_0001, 1'b1, '{1'b1, 45'h1_0000_0001, 6'd33}},
      '{ROW_PUSH,  '0, 32'h0000_0001, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h8000_0001, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h8000_0003, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h0001_0003, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h0001_0000, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h0001_0001, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h5555_5554, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'hAAAA_AAAA, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h2AAA_AAAA, 1'b0, '0},
      '{ROW_WRITE, ADDR_SPARE,      32'h0000_0000, 1'b0, '0},
      '{ROW_WRITE, ADDR_SPARE,      32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_WRITE, ADDR_MAX_VALUES, 32'hFFFF_0000, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'h1234_5678, 1'b1, '{1'b0, 45'h0, 6'd0}},
      '{ROW_WRITE, ADDR_MAX_VALUES, 32'h0000_0001, 1'b0, '0},
      '{ROW_PUSH,  '0, 32'hFFFF_FFFF, 1'b1, '{1'b0, 45'h0, 6'd0}},
      '{ROW_WRITE, ADDR_MAX_VALUES, 32'h0000_FFFF, 1'b0, '0},
      // a rejected value must not have moved the history
      '{ROW_PUSH,  '0, 32'h2AAA_AAAA, 1'b1, '{1'b1, 45'h0, 6'd1}},
      '{ROW_PUSH,  '0, 32'h0000_0000, 1'b0, '0}
   };

   function automatic chunk_type encode_sample(input logic [31:0] v);
      chunk_type r;
      logic [31:0] x;
      logic [63:0] acc;
      int lead, trail, m;
      r = '0;
      if (seen_count >= cap_limit) return r;
      r.accepted = 1'b1;
      if (seen_count == 0) begin
         acc = 64'(v);
         r.len = 6'd32;
      end else begin
         x = v ^ last_sample;
         if (x == 0) begin
            acc = '0;
            r.len = 6'd1;
         end else begin
            lead = 0;
            while (lead < 32 && !x[31-lead]) lead++;
            trail = 0;
            while (trail < 32 && !x[trail]) trail++;
            if (lead >= win_lead && trail >= win_trail) begin
               m = 32 - win_lead[4:0] - win_trail[4:0];
               acc = (64'd2 << m) | (64'(x >> win_trail[4:0]) & ((64'd1 << m) - 64'd1));
               r.len = 6'(2 + m);
            end else begin
               m = 32 - lead - trail;
               acc = (64'd3 << 11) | (64'(lead) << 6) | 64'(m);
               acc = (acc << m) | (64'(x >> trail) & ((64'd1 << m) - 64'd1));
               r.len = 6'(13 + m);
               win_lead = 8'(lead);
               win_trail = 6'(trail);
            end
         end
      end
      last_sample = v;
      seen_count = seen_count + 16'd1;
      r.bits = acc[xfse_pkg::CHUNK_W-1:0];
      return r;
   endfunction

   // mostly small xor steps, so the window is reused and moved often
   function automatic logic [31:0] next_sample(input bit open_all);
      logic [31:0] flip, span;
      int pick, lo, w;
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         flip = '0;
      end else if (pick < 55 && win_lead != xfse_pkg::NO_WINDOW) begin
         span = (32'hFFFF_FFFF >> win_lead[4:0]) & (32'hFFFF_FFFF << win_trail[4:0]);
         flip = $urandom & span;
         if ($urandom_range(0, 1) == 1) flip &= $urandom;
      end else if (pick < 85) begin
         lo = $urandom_range(0, 31);
         w = $urandom_range(1, 12);
         flip = ((32'hFFFF_FFFF >> (32 - w)) << lo) & $urandom;
      end else if (open_all && pick >= 93) begin
         flip = 32'h8000_0001 | $urandom;
      end else begin
         flip = $urandom;
      end
      // a full-width window would stick for good, so keep it for the tail
      if (!open_all && flip[31] && flip[0]) flip[0] = 1'b0;
      return last_sample ^ flip;
   endfunction

   task automatic flag_mismatch(input string what, input logic [63:0] got,
                                input logic [63:0] want);
      $display("tb: %s mismatch at %0t: got %0h want %0h", what, $realtime, got, want);
      errors++;
   endtask

   task automatic wait_drained();
      while (pending_chunks.size() != 0) @(negedge clock);
   endtask

   task automatic queue_expected(input chunk_type c);
      pending_chunks.insert(pending_chunks.size(), c);
   endtask

   task automatic send_value(input logic [31:0] v, input bit typed, input chunk_type want);
      chunk_type pred;
      int gap;
      gap = tx_calm ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      push <= 1'b1;
      req_value_bits <= v;
      do @(posedge clock); while (full);
      pred = encode_sample(v);
      queue_expected(typed ? want : pred);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [xfse_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [31:0] data);
      push <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == ADDR_MAX_VALUES) cap_limit = data[15:0];
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
   endtask

   // result side: pop held low for a drawn number of cycles after each transfer
   always @(negedge clock) begin
      if (pop_hold > 0) begin
         pop <= 1'b0;
         pop_hold--;
      end else begin
         pop <= !reset;
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_chunks.size() == 0) begin
            flag_mismatch("unexpected transfer", rsp_chunk_bits, 0);
         end else begin
            head = pending_chunks.pop_front();
            if (rsp_accepted !== head.accepted)
               flag_mismatch("accepted", rsp_accepted, head.accepted);
            if (rsp_chunk_bits !== head.bits)
               flag_mismatch("chunk_bits", rsp_chunk_bits, head.bits);
            if (rsp_chunk_length !== head.len)
               flag_mismatch("chunk_length", rsp_chunk_length, head.len);
         end
         results++;
         if (results % 40 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         pop_hold = rx_calm ? 0 : $urandom_range(0, 8);
      end
   end

   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int phase;
      int sent;
      int count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_WRITE) csr_write(plan[i].addr, plan[i].data);
         else send_value(plan[i].data, plan[i].typed, plan[i].want);
      end

      phase = 0;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (phase % 4 == 3)
            csr_write(ADDR_MAX_VALUES,
                      {16'($urandom), 16'(seen_count + $urandom_range(0, 30))});
         else
            csr_write(ADDR_MAX_VALUES, {16'($urandom), 16'hFFFF});
         if (phase % 5 == 2) csr_write(ADDR_SPARE, $urandom);
         count = 0;
         while (count < PHASE_ITEMS && sent < RANDOM_ITEMS) begin
            if (count % 20 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            send_value(next_sample(sent >= RANDOM_ITEMS - OPEN_TAIL), 1'b0, '0);
            count++;
            sent++;
         end
         phase++;
      end

      push <= 1'b0;
      wait_drained();
      repeat (8) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
sv/xfse_pkg.sv
sv/xfse_front.sv
sv/xfse_queue.sv
sv/xfse_back.sv
sv/xor_float_stream_encoder_unit.sv
sim/tb.sv
